// File: hw/rtl/rtns_pkg.sv
// Shared types and constants for the call record table search block.
// Used by rtns_front, rtns_fifo users, rtns_back and record_table_nearest_search.
// Depends on nothing.
package rtns_pkg;

  localparam int unsigned SecPerHour = 3600;
  localparam int unsigned SecPerMin  = 60;
  localparam int unsigned DayPerMon  = 30;
  localparam int unsigned DayPerYear = 365;

  localparam int unsigned PhoneW = 31;
  localparam int unsigned CityW  = 17;
  localparam int unsigned DurW   = 19;
  localparam int unsigned DateW  = 16;
  localparam int unsigned IdxW   = 4;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_NEAREST = 2'd2,
    OP_MIN     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    FLD_PHONE = 2'd0,
    FLD_CITY  = 2'd1,
    FLD_DUR   = 2'd2,
    FLD_DATE  = 2'd3
  } field_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_BAD_FIELD = 2'd2
  } status_e;

  // One stored call record
  typedef struct packed {
    logic [PhoneW-1:0] phone;
    logic [CityW-1:0]  city;
    logic [DurW-1:0]   dur;
    logic [DateW-1:0]  date;
  } rec_t;

  // Decoded command handed from front to back
  typedef struct packed {
    op_e               op;
    logic [IdxW-1:0]   idx;
    logic              in_range;
    field_e            sel;
    logic [PhoneW-1:0] key;
    rec_t              rec;
  } cmd_t;

  // One result item
  typedef struct packed {
    status_e         status;
    logic [IdxW-1:0] idx;
    rec_t            rec;
  } res_t;

endpackage

// File: hw/rtl/rtns_fifo.sv
// Small synchronous queue with push/full and pop/empty sides.
// Generic over the item type; no package dependency.
module rtns_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output T     data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                slot_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/rtns_front.sv
// Front end: decode one input item into a command for the back end.
// Builds duration and day count, picks the search key. Depends on rtns_pkg.
module rtns_front #(
  parameter int ENTRIES = 16
) (
  input  logic [1:0]                  opcode_i,
  input  logic [rtns_pkg::IdxW-1:0]   entry_index_i,
  input  logic [1:0]                  field_select_i,
  input  logic [rtns_pkg::PhoneW-1:0] phone_number_i,
  input  logic [rtns_pkg::CityW-1:0]  city_code_i,
  input  logic [6:0]                  hours_i,
  input  logic [5:0]                  minutes_i,
  input  logic [5:0]                  seconds_i,
  input  logic [4:0]                  day_i,
  input  logic [3:0]                  month_i,
  input  logic [6:0]                  year_i,
  output rtns_pkg::cmd_t              cmd_o
);

  logic [rtns_pkg::DurW-1:0]  dur;
  logic [rtns_pkg::DateW-1:0] date;
  rtns_pkg::field_e           sel;

  assign dur = rtns_pkg::DurW'(hours_i) * rtns_pkg::DurW'(rtns_pkg::SecPerHour)
             + rtns_pkg::DurW'(minutes_i) * rtns_pkg::DurW'(rtns_pkg::SecPerMin)
             + rtns_pkg::DurW'(seconds_i);
  assign date = rtns_pkg::DateW'(day_i)
              + rtns_pkg::DateW'(month_i) * rtns_pkg::DateW'(rtns_pkg::DayPerMon)
              + rtns_pkg::DateW'(year_i) * rtns_pkg::DateW'(rtns_pkg::DayPerYear);
  assign sel = rtns_pkg::field_e'(field_select_i);

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = rtns_pkg::op_e'(opcode_i);
    cmd_o.idx      = entry_index_i;
    cmd_o.in_range = (32'(entry_index_i) < ENTRIES);
    cmd_o.sel      = sel;
    cmd_o.rec      = '{phone: phone_number_i, city: city_code_i, dur: dur, date: date};
    case (sel)
      rtns_pkg::FLD_PHONE: cmd_o.key = phone_number_i;
      rtns_pkg::FLD_CITY:  cmd_o.key = rtns_pkg::PhoneW'(city_code_i);
      rtns_pkg::FLD_DUR:   cmd_o.key = rtns_pkg::PhoneW'(dur);
      default:             cmd_o.key = rtns_pkg::PhoneW'(date);
    endcase
  end

endmodule

// File: hw/rtl/rtns_back.sv
// Back end: record memory, valid bits and the one-slot-per-cycle search scan.
// Takes commands from the command queue, pushes results. Depends on rtns_pkg.
module rtns_back #(
  parameter int ENTRIES = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  rtns_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output rtns_pkg::res_t res_o
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_FIN,
    S_DONE
  } state_e;

  state_e                      state_q;
  rtns_pkg::cmd_t              cur_q;
  logic [ENTRIES-1:0]          valid_q;
  logic [AW-1:0]               addr_q;
  rtns_pkg::rec_t              mem_q [ENTRIES];
  rtns_pkg::rec_t              rd_data_q;
  logic                        rd_vld_q, rd_ok_q;
  logic [AW-1:0]               rd_slot_q;
  logic                        found_q;
  logic [rtns_pkg::PhoneW-1:0] best_metric_q;
  logic [AW-1:0]               best_slot_q;
  rtns_pkg::rec_t              best_rec_q;
  rtns_pkg::res_t              res_q;

  logic                        take;
  logic                        mem_we;
  logic [AW-1:0]               wr_addr;
  logic [rtns_pkg::PhoneW-1:0] fval, metric;
  logic                        better;

  assign take      = (state_q == S_IDLE) && !cmd_empty_i;
  assign cmd_pop_o = take;
  assign wr_addr   = AW'(cmd_i.idx);
  assign mem_we    = take && cmd_i.op == rtns_pkg::OP_WRITE && cmd_i.in_range;
  assign res_push_o = (state_q == S_DONE);
  assign res_o      = res_q;

  // Field of the slot just read, then its distance or raw value
  always_comb begin
    case (cur_q.sel)
      rtns_pkg::FLD_PHONE: fval = rd_data_q.phone;
      rtns_pkg::FLD_CITY:  fval = rtns_pkg::PhoneW'(rd_data_q.city);
      rtns_pkg::FLD_DUR:   fval = rtns_pkg::PhoneW'(rd_data_q.dur);
      default:             fval = rtns_pkg::PhoneW'(rd_data_q.date);
    endcase
    if (cur_q.op == rtns_pkg::OP_NEAREST) begin
      metric = (fval > cur_q.key) ? fval - cur_q.key : cur_q.key - fval;
    end else begin
      metric = fval;
    end
    better = rd_vld_q && rd_ok_q && (!found_q || metric < best_metric_q);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= cmd_i.rec;
    end
    rd_data_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cur_q         <= '0;
      valid_q       <= '0;
      addr_q        <= '0;
      rd_vld_q      <= 1'b0;
      rd_ok_q       <= 1'b0;
      rd_slot_q     <= '0;
      found_q       <= 1'b0;
      best_metric_q <= '0;
      best_slot_q   <= '0;
      best_rec_q    <= '0;
      res_q         <= '0;
    end else begin
      rd_vld_q <= 1'b0;
      if (better) begin
        found_q       <= 1'b1;
        best_metric_q <= metric;
        best_slot_q   <= rd_slot_q;
        best_rec_q    <= rd_data_q;
      end
      case (state_q)
        S_IDLE: begin
          if (take) begin
            cur_q <= cmd_i;
            if (cmd_i.op == rtns_pkg::OP_WRITE || cmd_i.op == rtns_pkg::OP_CLEAR) begin
              res_q.status <= rtns_pkg::STS_OK;
              res_q.idx    <= cmd_i.idx;
              // Echo the written record; clear and out-of-range slots answer zero
              res_q.rec    <= (cmd_i.in_range && cmd_i.op == rtns_pkg::OP_WRITE) ?
                              cmd_i.rec : '0;
              if (cmd_i.in_range) begin
                valid_q[wr_addr] <= (cmd_i.op == rtns_pkg::OP_WRITE);
              end
              state_q <= S_DONE;
            end else begin
              addr_q  <= '0;
              found_q <= 1'b0;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Issue one slot read per cycle
          rd_vld_q  <= 1'b1;
          rd_slot_q <= addr_q;
          rd_ok_q   <= valid_q[addr_q];
          if (addr_q == AW'(ENTRIES - 1)) begin
            state_q <= S_LAST;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        S_LAST: begin
          // Last slot is compared this cycle
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (found_q) begin
            res_q.status <= rtns_pkg::STS_OK;
            res_q.idx    <= rtns_pkg::IdxW'(best_slot_q);
            res_q.rec    <= best_rec_q;
          end else begin
            res_q.status <= rtns_pkg::STS_EMPTY;
            res_q.idx    <= '0;
            res_q.rec    <= '0;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!res_full_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/record_table_nearest_search.sv
// Top level of the call record table with nearest and minimum search.
// Instantiates rtns_front, rtns_fifo (command and result queues), rtns_back; uses rtns_pkg.
//
//   Channel  | Handshake        | Payload
//   ---------+------------------+-------------------------------------------------
//   command  | push in, full out| opcode, entry_index, field_select, phone..year
//   result   | pop in, empty out| status, found_index, out_phone/city/duration/date
//
// Write and clear register their result when taken and push it from S_DONE, which waits while the result queue is full.
// A search scans every slot of the record memory, one read per cycle on its single
// read port, then passes S_LAST, S_FIN and S_DONE before pushing its result.
// Reset clears all valid bits at once; stored records are not cleared.
// The command queue accepts items until full while the back end scans, and the result
// queue holds finished items while the consumer stalls.
module record_table_nearest_search #(
  parameter int ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  entry_index_i,
  input  logic [1:0]  field_select_i,
  input  logic [30:0] phone_number_i,
  input  logic [16:0] city_code_i,
  input  logic [6:0]  hours_i,
  input  logic [5:0]  minutes_i,
  input  logic [5:0]  seconds_i,
  input  logic [4:0]  day_i,
  input  logic [3:0]  month_i,
  input  logic [6:0]  year_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [3:0]  found_index_o,
  output logic [30:0] out_phone_o,
  output logic [16:0] out_city_o,
  output logic [18:0] out_duration_o,
  output logic [15:0] out_date_o
);

  rtns_pkg::cmd_t front_cmd, q_cmd;
  logic           cmd_empty, cmd_pop;
  rtns_pkg::res_t back_res, out_res;
  logic           res_full, res_push;

  // Decode: build duration, day count and search key
  rtns_front #(.ENTRIES(ENTRIES)) u_front (
    .opcode_i       (opcode_i),
    .entry_index_i  (entry_index_i),
    .field_select_i (field_select_i),
    .phone_number_i (phone_number_i),
    .city_code_i    (city_code_i),
    .hours_i        (hours_i),
    .minutes_i      (minutes_i),
    .seconds_i      (seconds_i),
    .day_i          (day_i),
    .month_i        (month_i),
    .year_i         (year_i),
    .cmd_o          (front_cmd)
  );

  // Hold decoded items between front and back
  rtns_fifo #(.T(rtns_pkg::cmd_t), .DEPTH(2)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (q_cmd)
  );

  // Execute: table update or full scan
  rtns_back #(.ENTRIES(ENTRIES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  // Hold finished items until the consumer pops them
  rtns_fifo #(.T(rtns_pkg::res_t), .DEPTH(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (out_res)
  );

  assign status_o       = out_res.status;
  assign found_index_o  = out_res.idx;
  assign out_phone_o    = out_res.rec.phone;
  assign out_city_o     = out_res.rec.city;
  assign out_duration_o = out_res.rec.dur;
  assign out_date_o     = out_res.rec.date;

`ifndef SYNTHESIS
  // Back end leaves its done state only when the result queue took the item
  a_res_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push && res_full |=> res_push && $stable(back_res))
    else $error("result item dropped while result queue full");

  // Back end never pops an empty command queue
  a_cmd_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");

  // An empty-table answer carries no record
  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && status_o == rtns_pkg::STS_EMPTY |->
      found_index_o == '0 && out_phone_o == '0 && out_date_o == '0)
    else $error("empty-table result carries record data");

  // Unknown-field status is never produced
  a_no_bad_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> status_o != rtns_pkg::STS_BAD_FIELD)
    else $error("unexpected unknown-field status");
`endif

endmodule
